>>> rtl/core/zsbf_pkg.sv
package zsbf_pkg;

	localparam int unsigned NPOS = 13;

	localparam int unsigned P_ZH0 = 0;
	localparam int unsigned P_ZH1 = 1;
	localparam int unsigned P_BK0 = 2;
	localparam int unsigned P_BK1 = 3;
	localparam int unsigned P_BK2 = 4;
	localparam int unsigned P_BK3 = 5;
	localparam int unsigned P_BK4 = 6;
	localparam int unsigned P_DAT = 7;
	localparam int unsigned P_TR0 = 8;
	localparam int unsigned P_TR1 = 9;
	localparam int unsigned P_TR2 = 10;
	localparam int unsigned P_TR3 = 11;
	localparam int unsigned P_OVR = 12;

	localparam logic [7:0]  ZLIB_CMF    = 8'h78;
	localparam logic [7:0]  ZLIB_FLG    = 8'h01;
	localparam logic [16:0] ADLER_MOD   = 17'd65521;
	localparam logic [15:0] BLOCK_MAX   = 16'hFFFF;
	localparam logic [15:0] ADLER_LO_INIT = 16'd1;
	localparam logic [15:0] ADLER_HI_INIT = 16'd0;

	typedef struct packed {
		logic        zhdr;
		logic        blk;
		logic        blk_last;
		logic [15:0] blk_len;
		logic        dat;
		logic [7:0]  dat_byte;
		logic        trl;
		logic [15:0] adl_hi;
		logic [15:0] adl_lo;
		logic        ovr;
	} cmd_t;

	function automatic logic [NPOS-1:0] cmd_mask(input cmd_t c);
		logic [NPOS-1:0] m;
		m = '0;
		m[P_ZH0] = c.zhdr;
		m[P_ZH1] = c.zhdr;
		m[P_BK0] = c.blk;
		m[P_BK1] = c.blk;
		m[P_BK2] = c.blk;
		m[P_BK3] = c.blk;
		m[P_BK4] = c.blk;
		m[P_DAT] = c.dat;
		m[P_TR0] = c.trl;
		m[P_TR1] = c.trl;
		m[P_TR2] = c.trl;
		m[P_TR3] = c.trl;
		m[P_OVR] = c.ovr;
		return m;
	endfunction

	function automatic logic [7:0] pos_byte(input cmd_t c, input int unsigned p);
		logic [7:0] b;
		unique case (p)
			P_ZH0: b = ZLIB_CMF;
			P_ZH1: b = ZLIB_FLG;
			P_BK0: b = {7'd0, c.blk_last};
			P_BK1: b = c.blk_len[7:0];
			P_BK2: b = c.blk_len[15:8];
			P_BK3: b = ~c.blk_len[7:0];
			P_BK4: b = ~c.blk_len[15:8];
			P_DAT: b = c.dat_byte;
			P_TR0: b = c.adl_hi[15:8];
			P_TR1: b = c.adl_hi[7:0];
			P_TR2: b = c.adl_lo[15:8];
			P_TR3: b = c.adl_lo[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/zsbf_front.sv
module zsbf_front
	import zsbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        accept,
	input  logic        func,
	input  logic [7:0]  data_byte,
	output cmd_t        cmd
);

	logic [31:0] total_q;
	logic [31:0] consumed_q;
	logic [15:0] blk_rem_q;
	logic [15:0] adl_lo_q;
	logic [15:0] adl_hi_q;
	logic        active_q;

	logic [31:0] consumed_d;
	logic [15:0] blk_rem_d;
	logic [15:0] adl_lo_d;
	logic [15:0] adl_hi_d;
	logic        active_d;

	logic        drop;
	logic        need_blk;
	logic [31:0] left;
	logic        left_small;
	logic [15:0] chunk;
	logic [16:0] lo_sum;
	logic [15:0] lo_new;
	logic [16:0] hi_sum;
	logic [15:0] hi_new;
	logic [31:0] consumed_inc;
	logic        closing;

	always_comb begin
		drop         = !active_q || (consumed_q >= total_q);
		need_blk     = (blk_rem_q == 16'd0);
		left         = total_q - consumed_q;
		left_small   = (left <= {16'd0, BLOCK_MAX});
		chunk        = left_small ? left[15:0] : BLOCK_MAX;
		lo_sum       = {1'b0, adl_lo_q} + {9'd0, data_byte};
		lo_new       = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
		hi_sum       = {1'b0, adl_hi_q} + {1'b0, lo_new};
		hi_new       = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
		consumed_inc = consumed_q + 32'd1;
		closing      = (consumed_inc == total_q);

		cmd        = '0;
		consumed_d = consumed_q;
		blk_rem_d  = blk_rem_q;
		adl_lo_d   = adl_lo_q;
		adl_hi_d   = adl_hi_q;
		active_d   = active_q;

		priority if (!func) begin
			cmd.zhdr   = 1'b1;
			consumed_d = 32'd0;
			blk_rem_d  = 16'd0;
			adl_lo_d   = ADLER_LO_INIT;
			adl_hi_d   = ADLER_HI_INIT;
			active_d   = 1'b1;
			if (total_q == 32'd0) begin
				cmd.blk      = 1'b1;
				cmd.blk_last = 1'b1;
				cmd.trl      = 1'b1;
				cmd.adl_lo   = ADLER_LO_INIT;
				cmd.adl_hi   = ADLER_HI_INIT;
				active_d     = 1'b0;
			end
		end else if (drop) begin
			cmd.ovr = 1'b1;
		end else begin
			cmd.blk      = need_blk;
			cmd.blk_last = left_small;
			cmd.blk_len  = chunk;
			cmd.dat      = 1'b1;
			cmd.dat_byte = data_byte;
			cmd.trl      = closing;
			cmd.adl_lo   = lo_new;
			cmd.adl_hi   = hi_new;
			adl_lo_d     = lo_new;
			adl_hi_d     = hi_new;
			consumed_d   = consumed_inc;
			blk_rem_d    = (need_blk ? chunk : blk_rem_q) - 16'd1;
			if (closing) begin
				active_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			consumed_q <= '0;
			blk_rem_q  <= '0;
			adl_lo_q   <= ADLER_LO_INIT;
			adl_hi_q   <= ADLER_HI_INIT;
			active_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (accept) begin
				consumed_q <= consumed_d;
				blk_rem_q  <= blk_rem_d;
				adl_lo_q   <= adl_lo_d;
				adl_hi_q   <= adl_hi_d;
				active_q   <= active_d;
			end
		end
	end

endmodule

>>> rtl/core/zsbf_fifo.sv
module zsbf_fifo
	import zsbf_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic is_empty,
	output logic is_full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign is_empty = (count_q == CW'(0));
	assign is_full  = (count_q == CW'(DEPTH));
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/zsbf_back.sv
module zsbf_back
	import zsbf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	input  logic       pop,
	output logic       head_done,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       stream_end,
	output logic       overrun
);

	logic [NPOS-1:0] done_q;
	logic [NPOS-1:0] remain;
	logic [NPOS-1:0] cur;
	logic            take;

	always_comb begin
		remain      = cmd_mask(head) & ~done_q;
		cur         = remain & (~remain + NPOS'(1));
		last_of_run = ((remain & (remain - NPOS'(1))) == '0);
		stream_end  = cur[P_TR3];
		overrun     = cur[P_OVR];
		out_byte    = 8'd0;
		for (int unsigned i = 0; i < NPOS; i++) begin
			if (cur[i]) begin
				out_byte = out_byte | pos_byte(head, i);
			end
		end
		take      = pop && head_valid;
		head_done = take && last_of_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (take) begin
			done_q <= last_of_run ? '0 : (done_q | cur);
		end
	end

endmodule

>>> rtl/core/zlib_stored_block_framer.sv
// zlib stream framer with stored deflate blocks and Adler-32 trailer.
// Write total_length through cfg_we/cfg_wdata while the block is idle.
// Input side is a queue: a word is taken when push is high and full is low.
// func 0 opens a stream (zlib header 78 01); func 1 carries one data_byte.
// Output side is a queue: the oldest stream byte sits on out_byte while empty
// is low and leaves when pop is high. last_of_run marks the final byte caused
// by one input word, stream_end the last Adler-32 byte, overrun a dropped byte.
// The front classifies each word in its cycle of acceptance, updates the byte
// count and Adler-32 sums, and writes one command into a QUEUE_DEPTH deep
// queue; the back expands each command into 1 to 11 output bytes.
// A word's bytes show once its command is registered in the queue and reaches
// its head. Throughput: one input word per cycle while each yields one byte and
// pop stays high; a word with a block header yields 6 bytes, a closing one 4
// more, a start 2 (11 with zero length), limited by the single output byte port.
// Reset clears the queue, closes any stream and zeroes total_length.
// When pop stays low the queue fills and full rises; nothing is lost.
module zlib_stored_block_framer
	import zsbf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        stream_end,
	output logic        overrun
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic accept;
	logic head_done;

	assign accept = push && !full;

	zsbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.func      (func),
		.data_byte (data_byte),
		.cmd       (front_cmd)
	);

	zsbf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_cmd   (front_cmd),
		.rd_en    (head_done),
		.rd_cmd   (head_cmd),
		.is_empty (empty),
		.is_full  (full)
	);

	zsbf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_cmd),
		.head_valid  (!empty),
		.pop         (pop),
		.head_done   (head_done),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_end  (stream_end),
		.overrun     (overrun)
	);

endmodule
